>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge out of reset.
`define CHK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication.
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed");
`endif

>>> rtl/core/nptw_pkg.sv
// Package for the nested page table walker: codes, types and helpers.
// No dependencies.
`default_nettype none
package nptw_pkg;
  localparam int unsigned AddrW = 52;
  localparam int unsigned VaW   = 48;
  localparam int unsigned DataW = 64;

  typedef enum logic [1:0] {
    MODE_GVA  = 2'd0,
    MODE_GPA  = 2'd1,
    MODE_DATA = 2'd2,
    MODE_BAD  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_ROOT     = 3'd1,
    ST_GUEST_NP    = 3'd2,
    ST_NESTED_NP   = 3'd3,
    ST_UNEXPECTED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_NESTED = 2'd1,
    PH_GUEST  = 2'd2
  } phase_e;

  typedef enum logic {
    CFG_GUEST_ROOT  = 1'b0,
    CFG_NESTED_ROOT = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgIdxW = 1;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    mode_e             mode;
    logic [VaW-1:0]    req;
    logic [DataW-1:0]  data;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [AddrW-1:0]  addr;
    status_e           status;
  } result_t;

  function automatic logic [8:0] tbl_index(input logic [AddrW-1:0] a,
                                           input logic [1:0] lvl);
    logic [8:0] r;
    begin
      unique case (lvl)
        2'd0: r = a[47:39];
        2'd1: r = a[38:30];
        2'd2: r = a[29:21];
        default: r = a[20:12];
      endcase
      return r;
    end
  endfunction

  function automatic logic [AddrW-1:0] entry_addr(input logic [AddrW-1:0] base,
                                                  input logic [8:0] idx);
    return {base[AddrW-1:12], 12'd0} + {{(AddrW-12){1'b0}}, idx, 3'd0};
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/nptw_if.sv
// Valid/ready channel interface carrying one payload struct.
// Payload type is a parameter; no package dependency.
`default_nettype none
interface nptw_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/nptw_front.sv
// Front part: takes input transfers, masks request bits, pushes into a queue.
// Uses nptw_pkg.
`default_nettype none
module nptw_front #(
  parameter int unsigned VIRT_ADDR_BITS = 48
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [1:0]      mode_i,
  input  wire logic [47:0]     req_i,
  input  wire logic [63:0]     data_i,
  output logic                 q_valid_o,
  input  wire logic            q_ready_i,
  output nptw_pkg::item_t      q_item_o
);
  // Two-entry queue.
  nptw_pkg::item_t mem_q [2];
  logic [0:0] wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;
  logic [47:0] req_mask;
  nptw_pkg::item_t it;

  assign req_mask = (VIRT_ADDR_BITS >= 48) ? {48{1'b1}} :
                    ((48'd1 << VIRT_ADDR_BITS) - 48'd1);
  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_item_o = mem_q[rp_q];

  always_comb begin
    it.mode = nptw_pkg::mode_e'(mode_i);
    it.req  = req_i & req_mask;
    it.data = data_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= it;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/nptw_back.sv
// Back part: walk state machine, one step per queued item, result register.
// Uses nptw_pkg.
`default_nettype none
module nptw_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [51:0]          guest_root_i,
  input  wire logic [51:0]          nested_root_i,
  input  wire logic                 q_valid_i,
  output logic                      q_ready_o,
  input  wire nptw_pkg::item_t      q_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output nptw_pkg::result_t         out_res_o
);
  nptw_pkg::phase_e phase_q, phase_d;
  logic gact_q, gact_d;
  logic [1:0] glvl_q, glvl_d, nlvl_q, nlvl_d;
  logic [47:0] sva_q, sva_d;
  logic [51:0] pgpa_q, pgpa_d;
  logic ov_q;
  nptw_pkg::result_t res_q, res_d;
  logic step;
  logic [51:0] e, ns_gpa, leaf;
  logic ns_go, ns_for_guest;
  logic is_large;

  assign q_ready_o = !ov_q || out_ready_i;
  assign step = q_valid_i && q_ready_o;
  assign out_valid_o = ov_q;
  assign out_res_o = res_q;
  assign e = q_item_i.data[51:0];
  assign is_large = q_item_i.data[7];

  always_comb begin
    phase_d = phase_q; gact_d = gact_q; glvl_d = glvl_q; nlvl_d = nlvl_q;
    sva_d = sva_q; pgpa_d = pgpa_q;
    res_d = '{kind: 1'b1, addr: '0, status: nptw_pkg::ST_UNEXPECTED};
    ns_go = 1'b0; ns_for_guest = 1'b0; ns_gpa = '0; leaf = '0;
    unique case (q_item_i.mode)
      nptw_pkg::MODE_GVA: begin
        if (guest_root_i == '0) begin
          phase_d = nptw_pkg::PH_IDLE;
          res_d.status = nptw_pkg::ST_NO_ROOT;
        end else begin
          sva_d = q_item_i.req; glvl_d = 2'd0;
          ns_go = 1'b1; ns_for_guest = 1'b1;
          ns_gpa = nptw_pkg::entry_addr(guest_root_i,
                                        nptw_pkg::tbl_index({4'd0, q_item_i.req}, 2'd0));
        end
      end
      nptw_pkg::MODE_GPA: begin
        sva_d = q_item_i.req;
        ns_go = 1'b1; ns_gpa = {4'd0, q_item_i.req};
      end
      nptw_pkg::MODE_DATA: begin
        if (phase_q == nptw_pkg::PH_NESTED) begin
          if (!q_item_i.data[0]) begin
            phase_d = nptw_pkg::PH_IDLE;
            res_d.status = nptw_pkg::ST_NESTED_NP;
          end else if ((nlvl_q == 2'd1 && is_large) || (nlvl_q == 2'd2 && is_large) ||
                       nlvl_q == 2'd3) begin
            if (nlvl_q == 2'd1 && is_large) leaf = {e[51:30], pgpa_q[29:0]};
            else if (nlvl_q == 2'd2) leaf = {e[51:21], pgpa_q[20:0]};
            else leaf = {e[51:12], pgpa_q[11:0]};
            res_d.addr = leaf; res_d.status = nptw_pkg::ST_OK;
            if (gact_q) begin
              phase_d = nptw_pkg::PH_GUEST; res_d.kind = 1'b0;
            end else begin
              phase_d = nptw_pkg::PH_IDLE;
            end
          end else begin
            nlvl_d = nlvl_q + 2'd1;
            res_d.kind = 1'b0; res_d.status = nptw_pkg::ST_OK;
            res_d.addr = nptw_pkg::entry_addr(e, nptw_pkg::tbl_index(pgpa_q, nlvl_d));
          end
        end else if (phase_q == nptw_pkg::PH_GUEST) begin
          if (!q_item_i.data[0]) begin
            phase_d = nptw_pkg::PH_IDLE;
            res_d.status = nptw_pkg::ST_GUEST_NP;
          end else begin
            ns_go = 1'b1;
            if (glvl_q == 2'd1 && is_large) ns_gpa = {e[51:30], sva_q[29:0]};
            else if (glvl_q == 2'd2 && is_large) ns_gpa = {e[51:21], sva_q[20:0]};
            else if (glvl_q == 2'd3) ns_gpa = {e[51:12], sva_q[11:0]};
            else begin
              glvl_d = glvl_q + 2'd1; ns_for_guest = 1'b1;
              ns_gpa = nptw_pkg::entry_addr(e, nptw_pkg::tbl_index({4'd0, sva_q}, glvl_d));
            end
          end
        end
      end
      default: ;
    endcase
    if (ns_go) begin
      pgpa_d = ns_gpa; gact_d = ns_for_guest; nlvl_d = 2'd0;
      phase_d = nptw_pkg::PH_NESTED;
      res_d.kind = 1'b0; res_d.status = nptw_pkg::ST_OK;
      res_d.addr = nptw_pkg::entry_addr(nested_root_i, nptw_pkg::tbl_index(ns_gpa, 2'd0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nptw_pkg::PH_IDLE; gact_q <= 1'b0; glvl_q <= '0; nlvl_q <= '0;
      sva_q <= '0; pgpa_q <= '0; ov_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d; gact_q <= gact_d; glvl_q <= glvl_d; nlvl_q <= nlvl_d;
        sva_q <= sva_d; pgpa_q <= pgpa_d;
      end
      if (step) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res_d;
  end
endmodule
`default_nettype wire

>>> rtl/core/nested_page_table_walker.sv
// Top level of the two-dimensional page walker.
// Uses nptw_pkg, nptw_if, nptw_front and nptw_back.
// One item per cycle sustained while out_if.ready keeps the result register free:
// each item is one walk step in the back part's single combinational stage; its
// result passes through a queue entry, then the result register. Every item
// yields one result.
`default_nettype none
module nested_page_table_walker #(
  parameter int unsigned VIRT_ADDR_BITS = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [51:0] cfg_data_i,
  nptw_if.sink             in_if,
  nptw_if.source           out_if
);
  logic [51:0] groot_q, nroot_q;
  logic qv, qr;
  nptw_pkg::item_t qi;
  nptw_pkg::result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groot_q <= '0; nroot_q <= '0;
    end else if (cfg_we_i) begin
      unique case (nptw_pkg::cfg_idx_e'(cfg_idx_i))
        nptw_pkg::CFG_GUEST_ROOT:  groot_q <= cfg_data_i;
        nptw_pkg::CFG_NESTED_ROOT: nroot_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nptw_front #(.VIRT_ADDR_BITS(VIRT_ADDR_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .mode_i(in_if.data.mode), .req_i(in_if.data.req),
    .data_i(in_if.data.data),
    .q_valid_o(qv), .q_ready_i(qr), .q_item_o(qi)
  );

  nptw_back u_back (
    .clk_i, .rst_ni,
    .guest_root_i(groot_q), .nested_root_i(nroot_q),
    .q_valid_i(qv), .q_ready_o(qr), .q_item_i(qi),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_res_o(res)
  );

  always_comb begin
    out_if.data.kind   = res.kind;
    out_if.data.addr   = res.addr;
    out_if.data.status = res.status;
  end
endmodule
`default_nettype wire

>>> rtl/core/nptw_checker.sv
// Port-level checker for the walker, bound to the top level.
// Uses assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module nptw_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_kind,
  input wire logic [2:0]  out_status,
  input wire logic [51:0] out_addr
);
  `CHK_IMPL(a_status_range, out_valid, out_status <= nptw_pkg::ST_UNEXPECTED)
  `CHK_IMPL(a_req_ok, out_valid && !out_kind, out_status == nptw_pkg::ST_OK)
  `CHK_IMPL(a_fail_zero, out_valid && out_status != nptw_pkg::ST_OK, out_addr == 52'd0)
  `CHK_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_addr))
endmodule

bind nested_page_table_walker nptw_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_kind(out_if.data.kind), .out_status(out_if.data.status),
  .out_addr(out_if.data.addr)
);
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for nested_page_table_walker: a queue-fed driver, a
// stalling monitor and an in-bench walk predictor that computes each result.
// Depends on nptw_pkg, nptw_if and the walker RTL.
`timescale 1ns / 100ps
module tb;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned ItemsPerCfg = 350;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [51:0] cfg_data_i;

  nptw_if #(.T(nptw_pkg::item_t)) req_ch ();
  nptw_if #(.T(nptw_pkg::result_t)) rsp_ch ();

  nested_page_table_walker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (req_ch),
    .out_if     (rsp_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Walk predictor state.
  logic [51:0]       guest_root_q, nested_root_q;
  nptw_pkg::phase_e  walk_phase;
  logic              serving_guest;
  logic [1:0]        guest_lvl, nested_lvl;
  logic [47:0]       saved_va;
  logic [51:0]       gpa_under_walk;

  nptw_pkg::item_t   pending_items[$];
  nptw_pkg::result_t expected_results[$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned items_sent;

  function automatic logic [8:0] level_index(input logic [51:0] a, input logic [1:0] lvl);
    return 9'((a >> (39 - 9 * lvl)) & 52'h1FF);
  endfunction

  function automatic logic [51:0] slot_addr(input logic [51:0] base, input logic [8:0] idx);
    return {base[51:12], 12'd0} + {40'd0, idx, 3'd0};
  endfunction

  function automatic nptw_pkg::result_t read_req(input logic [51:0] a);
    nptw_pkg::result_t r;
    r.kind = 1'b0;
    r.addr = a;
    r.status = nptw_pkg::ST_OK;
    return r;
  endfunction

  function automatic nptw_pkg::result_t done_with(input logic [51:0] a,
                                                  input nptw_pkg::status_e st);
    nptw_pkg::result_t r;
    walk_phase = nptw_pkg::PH_IDLE;
    r.kind = 1'b1;
    r.addr = a;
    r.status = st;
    return r;
  endfunction

  function automatic nptw_pkg::result_t begin_nested(input logic [51:0] gpa,
                                                     input logic for_guest);
    gpa_under_walk = gpa;
    serving_guest = for_guest;
    nested_lvl = 2'd0;
    walk_phase = nptw_pkg::PH_NESTED;
    return read_req(slot_addr(nested_root_q, level_index(gpa, 2'd0)));
  endfunction

  function automatic nptw_pkg::result_t nested_leaf(input logic [51:0] hpa);
    if (serving_guest) begin
      walk_phase = nptw_pkg::PH_GUEST;
      return read_req(hpa);
    end
    return done_with(hpa, nptw_pkg::ST_OK);
  endfunction

  function automatic nptw_pkg::result_t nested_entry(input logic [63:0] e);
    logic [51:0] g;
    g = gpa_under_walk;
    if (!e[0]) return done_with('0, nptw_pkg::ST_NESTED_NP);
    if (nested_lvl == 2'd1 && e[7]) return nested_leaf({e[51:30], g[29:0]});
    if (nested_lvl == 2'd2 && e[7]) return nested_leaf({e[51:21], g[20:0]});
    if (nested_lvl == 2'd3) return nested_leaf({e[51:12], g[11:0]});
    nested_lvl = nested_lvl + 2'd1;
    return read_req(slot_addr(e[51:0], level_index(g, nested_lvl)));
  endfunction

  function automatic nptw_pkg::result_t guest_entry(input logic [63:0] e);
    logic [51:0] va;
    va = {4'd0, saved_va};
    if (!e[0]) return done_with('0, nptw_pkg::ST_GUEST_NP);
    if (guest_lvl == 2'd1 && e[7]) return begin_nested({e[51:30], va[29:0]}, 1'b0);
    if (guest_lvl == 2'd2 && e[7]) return begin_nested({e[51:21], va[20:0]}, 1'b0);
    if (guest_lvl == 2'd3) return begin_nested({e[51:12], va[11:0]}, 1'b0);
    guest_lvl = guest_lvl + 2'd1;
    return begin_nested(slot_addr(e[51:0], level_index(va, guest_lvl)), 1'b1);
  endfunction

  function automatic nptw_pkg::result_t walk_step(input nptw_pkg::item_t it);
    nptw_pkg::result_t r;
    r.kind = 1'b1;
    r.addr = '0;
    r.status = nptw_pkg::ST_UNEXPECTED;
    case (it.mode)
      nptw_pkg::MODE_GVA: begin
        if (guest_root_q == '0) begin
          r = done_with('0, nptw_pkg::ST_NO_ROOT);
        end else begin
          saved_va = it.req;
          guest_lvl = 2'd0;
          r = begin_nested(slot_addr(guest_root_q, level_index({4'd0, it.req}, 2'd0)),
                           1'b1);
        end
      end
      nptw_pkg::MODE_GPA: begin
        saved_va = it.req;
        r = begin_nested({4'd0, it.req}, 1'b0);
      end
      nptw_pkg::MODE_DATA: begin
        if (walk_phase == nptw_pkg::PH_NESTED) r = nested_entry(it.data);
        else if (walk_phase == nptw_pkg::PH_GUEST) r = guest_entry(it.data);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send(input nptw_pkg::mode_e m, input logic [47:0] a, input logic [63:0] d);
    nptw_pkg::item_t it;
    it.mode = m;
    it.req = a;
    it.data = d;
    expected_results.push_back(walk_step(it));
    pending_items.push_back(it);
    items_sent++;
  endtask

  // style: 0 random, 1 large always, 2 never large, 3 all ones, 4 all zeros
  function automatic logic [63:0] table_word(input int style);
    logic [63:0] e;
    e = {$urandom, $urandom};
    case (style)
      1: e[7] = 1'b1;
      2: begin e[0] = 1'b1; e[7] = 1'b0; end
      3: e = '1;
      4: e = '0;
      default: begin
        e[0] = ($urandom_range(0, 14) != 0);
        e[7] = ($urandom_range(0, 2) == 0);
      end
    endcase
    if (style == 1) e[0] = 1'b1;
    return e;
  endfunction

  task automatic walk(input nptw_pkg::mode_e m, input logic [47:0] a, input int style,
                      input bit noisy);
    int steps;
    steps = 0;
    send(m, a, {$urandom, $urandom});
    while (walk_phase != nptw_pkg::PH_IDLE && steps < 40) begin
      if (noisy && $urandom_range(0, 79) == 0) begin
        // drop the walk with a new request, or poke with a bad mode
        if ($urandom_range(0, 1) != 0)
          send(nptw_pkg::MODE_BAD, 48'({$urandom, $urandom}), '0);
        else
          send(nptw_pkg::mode_e'($urandom_range(0, 1)), 48'({$urandom, $urandom}), '0);
      end else begin
        send(nptw_pkg::MODE_DATA, 48'({$urandom, $urandom}), table_word(style));
      end
      steps++;
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0 || req_ch.valid)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input nptw_pkg::cfg_idx_e idx, input logic [51:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == nptw_pkg::CFG_GUEST_ROOT) guest_root_q = v;
    else nested_root_q = v;
    @(posedge clk_i);
  endtask

  // Driver.
  int unsigned send_gap;
  bit send_burst;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          req_ch.data <= pending_items.pop_front();
          req_ch.valid <= 1'b1;
          if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
          send_gap <= send_burst ? 0 : $urandom_range(0, 9);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  int unsigned stall;
  bit recv_burst;
  always @(posedge clk_i) begin
    nptw_pkg::result_t got, want;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: kind %0d addr %h status %0d",
                     got.kind, got.addr, got.status);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.addr !== want.addr
              || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected kind %0d addr %h status %0d, got %0d %h %0d",
                       want.kind, want.addr, want.status,
                       got.kind, got.addr, got.status);
          end
        end
        if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
        stall = recv_burst ? 0 : $urandom_range(0, 9);
        rsp_ch.ready <= (stall == 0);
      end else if (stall != 0) begin
        stall--;
        rsp_ch.ready <= (stall == 0);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("nested_page_table_walker regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    guest_root_q = '0;
    nested_root_q = '0;
    walk_phase = nptw_pkg::PH_IDLE;
    serving_guest = 1'b0;
    guest_lvl = '0;
    nested_lvl = '0;
    saved_va = '0;
    gpa_under_walk = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      case (p)
        0: begin
          write_reg(nptw_pkg::CFG_GUEST_ROOT, '0);
          write_reg(nptw_pkg::CFG_NESTED_ROOT, '0);
        end
        1: begin
          write_reg(nptw_pkg::CFG_GUEST_ROOT, '1);
          write_reg(nptw_pkg::CFG_NESTED_ROOT, '1);
        end
        2: begin
          write_reg(nptw_pkg::CFG_GUEST_ROOT, 52'h0_0000_0000_0FFF);
          write_reg(nptw_pkg::CFG_NESTED_ROOT, 52'h0_0000_0000_0FFF);
        end
        default: begin
          write_reg(nptw_pkg::CFG_GUEST_ROOT, 52'({$urandom, $urandom}) | 52'h1000);
          write_reg(nptw_pkg::CFG_NESTED_ROOT, 52'({$urandom, $urandom}));
        end
      endcase
      if (p < 2) begin
        // edges: no root, bad mode and data while idle, large and 4K leaves
        send(nptw_pkg::MODE_GVA, '1, '0);
        send(nptw_pkg::MODE_BAD, '1, '1);
        send(nptw_pkg::MODE_DATA, '0, '1);
        walk(nptw_pkg::MODE_GPA, '1, 1, 0);
        walk(nptw_pkg::MODE_GVA, '1, 2, 0);
        walk(nptw_pkg::MODE_GVA, '0, 3, 0);
        walk(nptw_pkg::MODE_GPA, '0, 4, 0);
        walk(nptw_pkg::MODE_GVA, 48'h8000_4020_1000, 1, 0);
      end
      target = items_sent + ItemsPerCfg;
      while (items_sent < target) begin
        case ($urandom_range(0, 19))
          0: send(nptw_pkg::MODE_DATA, 48'({$urandom, $urandom}), {$urandom, $urandom});
          1: send(nptw_pkg::MODE_BAD, 48'({$urandom, $urandom}), {$urandom, $urandom});
          2, 3, 4, 5, 6: walk(nptw_pkg::MODE_GPA, 48'({$urandom, $urandom}), 0, 1);
          default: walk(nptw_pkg::MODE_GVA, 48'({$urandom, $urandom}), 0, 1);
        endcase
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("nested_page_table_walker regression: pass");
    end else begin
      $display("nested_page_table_walker regression: fail");
    end
    $finish;
  end
endmodule
